### hdl/srld_pkg.sv
// Shared types and constants for the subpicture RLE line decoder.
// Depends on nothing; used by srld_front, srld_back and the top level.
`default_nettype none

package srld_pkg;

	// Field widths
	localparam int unsigned WIDTH_W = 13;
	localparam int unsigned MAP_W   = 16;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned CFG_A_W = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_A_W-1:0] REG_LINE_WIDTH  = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_PALETTE_MAP = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_ALPHA_MAP   = 2'd2;

	// Register reset values
	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST  = 13'd720;
	localparam logic [MAP_W-1:0]   PALETTE_MAP_RST = 16'h0000;
	localparam logic [MAP_W-1:0]   ALPHA_MAP_RST   = 16'h000F;

	// Code thresholds by nibble count
	localparam logic [15:0] THR_1NIB = 16'h0004;
	localparam logic [15:0] THR_2NIB = 16'h0010;
	localparam logic [15:0] THR_3NIB = 16'h0040;
	localparam logic [15:0] THR_CR   = 16'h0100;

	// Byte as queued between front and back
	typedef struct packed {
		logic [NIB_W-1:0] nib_hi;
		logic [NIB_W-1:0] nib_lo;
		logic             lo_short; // low nibble alone forms a complete code
	} byte_item_t;

	// Configuration as seen by the back end
	typedef struct packed {
		logic [WIDTH_W-1:0] width;   // clamped line width
		logic [MAP_W-1:0]   palette;
		logic [MAP_W-1:0]   alpha;
	} cfg_t;

endpackage : srld_pkg

`default_nettype wire

### hdl/srld_front.sv
// Front end: accepts stream bytes, splits and classifies them into a 2-entry queue.
// Depends on srld_pkg.
`default_nettype none

module srld_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          data_byte,
	output logic                     q_valid,
	output srld_pkg::byte_item_t     q_item,
	input  wire logic                q_pop
);

	srld_pkg::byte_item_t mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;
	srld_pkg::byte_item_t new_item;

	// Classify incoming byte
	always_comb begin
		new_item.nib_hi   = data_byte[7:4];
		new_item.nib_lo   = data_byte[3:0];
		new_item.lo_short = ({12'd0, data_byte[3:0]} >= srld_pkg::THR_1NIB);
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule : srld_front

`default_nettype wire

### hdl/srld_back.sv
// Back end: decodes nibbles into runs, one per cycle unless stalled.
// Holds the result register. Depends on srld_pkg.
`default_nettype none

module srld_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire srld_pkg::cfg_t                       cfg,
	input  wire logic                                 q_valid,
	input  wire srld_pkg::byte_item_t                 q_item,
	output logic                                      q_pop,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [srld_pkg::WIDTH_W-1:0]              run_length,
	output logic [srld_pkg::IDX_W-1:0]                clut_index,
	output logic                                      opaque,
	output logic                                      end_of_line,
	output logic                                      last
);

	localparam int unsigned W = srld_pkg::WIDTH_W;

	// Decoder state
	logic [11:0]  accum_q;
	logic [1:0]   count_q;
	logic [W-1:0] col_q;
	logic         nib_sel_q;
	logic         out_valid_q;

	// Result register
	logic [W-1:0]                 len_s1;
	logic [srld_pkg::IDX_W-1:0]   idx_s1;
	logic                         opq_s1;
	logic                         eol_s1;
	logic                         last_s1;

	logic [3:0]   nib;
	logic [2:0]   cnt;
	logic [15:0]  code;
	logic         done;
	logic         is_cr;
	logic [W:0]   run_num;
	logic [1:0]   color;
	logic [W-1:0] remain;
	logic [W-1:0] len;
	logic         eol;
	logic         res_last;
	logic [3:0]   sel_idx;
	logic [3:0]   sel_alpha;
	logic         step;

	// Code assembly and completion test
	always_comb begin
		nib  = nib_sel_q ? q_item.nib_lo : q_item.nib_hi;
		cnt  = {1'b0, count_q} + 3'd1;
		code = {accum_q, nib};
		case (cnt)
			3'd1:    done = (code >= srld_pkg::THR_1NIB);
			3'd2:    done = (code >= srld_pkg::THR_2NIB);
			3'd3:    done = (code >= srld_pkg::THR_3NIB);
			default: done = 1'b1;
		endcase
		is_cr   = (cnt == 3'd4) && (code < srld_pkg::THR_CR);
		run_num = code[15:2];
		color   = code[1:0];
	end

	// Run length, clipping and line end
	always_comb begin
		remain    = (cfg.width > col_q) ? (cfg.width - col_q) : '0;
		sel_idx   = cfg.palette[{color, 2'b00} +: 4];
		sel_alpha = cfg.alpha[{color, 2'b00} +: 4];
		if (is_cr) begin
			len = remain;
			eol = 1'b1;
		end else begin
			len = (run_num < {1'b0, remain}) ? run_num[W-1:0] : remain;
			eol = (({1'b0, col_q} + {1'b0, len}) >= {1'b0, cfg.width});
		end
		// On the high nibble, the low nibble completes a code only if it stands alone
		res_last = nib_sel_q || eol || !q_item.lo_short;
	end

	assign step  = q_valid && (!out_valid_q || !out_stall);
	assign q_pop = step && (nib_sel_q || (done && eol));

	// Decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			count_q     <= '0;
			col_q       <= '0;
			nib_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= done;
				nib_sel_q   <= !q_pop;
				if (done) begin
					accum_q <= '0;
					count_q <= '0;
					col_q   <= eol ? '0 : (col_q + len);
				end else begin
					accum_q <= code[11:0];
					count_q <= cnt[1:0];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (step && done) begin
			len_s1  <= len;
			idx_s1  <= is_cr ? '0 : sel_idx;
			opq_s1  <= is_cr ? 1'b0 : sel_alpha[3];
			eol_s1  <= eol;
			last_s1 <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign run_length  = len_s1;
	assign clut_index  = idx_s1;
	assign opaque      = opq_s1;
	assign end_of_line = eol_s1;
	assign last        = last_s1;

endmodule : srld_back

`default_nettype wire

### hdl/subpicture_rle_line_decoder_core.sv
// Subpicture RLE line decoder, top level: configuration registers, front/back hookup.
// Depends on srld_pkg, srld_front and srld_back.
//
// Usage:
//   Input channel: one byte of a line's run-length coded stream per item
//   (in_valid / in_stall / data_byte). High nibble is decoded first.
//   Output channel: one pixel run per item (out_valid / out_stall) with
//   run_length, clut_index, opaque, end_of_line and last. A byte gives
//   zero, one or two runs; last marks the final run of a byte.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 line_width, 1 palette_map, 2 alpha_map); write only while idle.
// Timing:
//   A byte goes into a 2-entry queue; the back end decodes one nibble per
//   cycle unless stalled, and runs leave at up to one per cycle.
//   From an empty queue a run goes through the queue, then the result register.
// Reset: clears the queue, code assembly and column; registers return to
//   line_width 720, palette_map 0, alpha_map 0x000F. No clearing pass.
// Stall: a stalled run holds in the result register; the back end halts,
//   the queue fills and in_stall rises once two bytes are waiting.
`default_nettype none

module subpicture_rle_line_decoder_core #(
	parameter int unsigned MAX_LINE_WIDTH = 4096
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [7:0]                           data_byte,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [srld_pkg::WIDTH_W-1:0]              run_length,
	output logic [srld_pkg::IDX_W-1:0]                clut_index,
	output logic                                      opaque,
	output logic                                      end_of_line,
	output logic                                      last,
	input  wire logic                                 cfg_we,
	input  wire logic [srld_pkg::CFG_A_W-1:0]         cfg_index,
	input  wire logic [srld_pkg::MAP_W-1:0]           cfg_data
);

	localparam logic [srld_pkg::WIDTH_W-1:0] MAX_W = srld_pkg::WIDTH_W'(MAX_LINE_WIDTH);

	logic [srld_pkg::WIDTH_W-1:0] line_width_q;
	logic [srld_pkg::MAP_W-1:0]   palette_map_q;
	logic [srld_pkg::MAP_W-1:0]   alpha_map_q;
	srld_pkg::cfg_t               cfg;
	logic                         q_valid;
	logic                         q_pop;
	srld_pkg::byte_item_t         q_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q  <= srld_pkg::LINE_WIDTH_RST;
			palette_map_q <= srld_pkg::PALETTE_MAP_RST;
			alpha_map_q   <= srld_pkg::ALPHA_MAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				srld_pkg::REG_LINE_WIDTH:  line_width_q  <= cfg_data[srld_pkg::WIDTH_W-1:0];
				srld_pkg::REG_PALETTE_MAP: palette_map_q <= cfg_data;
				srld_pkg::REG_ALPHA_MAP:   alpha_map_q   <= cfg_data;
				default:                   ;
			endcase
		end
	end

	// Effective width: zero reads as one, clamp to the maximum
	always_comb begin
		if (line_width_q == '0) begin
			cfg.width = srld_pkg::WIDTH_W'(1);
		end else if (line_width_q > MAX_W) begin
			cfg.width = MAX_W;
		end else begin
			cfg.width = line_width_q;
		end
		cfg.palette = palette_map_q;
		cfg.alpha   = alpha_map_q;
	end

	srld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	srld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.run_length  (run_length),
		.clut_index  (clut_index),
		.opaque      (opaque),
		.end_of_line (end_of_line),
		.last        (last)
	);

	// A run never exceeds the line
	a_len_le_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_length <= cfg.width))
		else $error("run longer than line width");

	// A run that does not close the line is never empty
	a_mid_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !end_of_line) |-> (run_length != '0))
		else $error("empty run before line end");

	// A run that ends the line while the byte continues cannot exist
	a_eol_implies_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_line) |-> last)
		else $error("line end not marked as final run of byte");

endmodule : subpicture_rle_line_decoder_core

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for subpicture_rle_line_decoder_core: feeds coded line bytes, predicts
// the pixel runs in a scoreboard and checks every run that leaves the block.
// Depends on srld_pkg and the decoder RTL.

module tb_top;

	localparam int unsigned MAX_W         = 4096;
	localparam int unsigned SETTLE_CYCLES = 12;    // two queued bytes plus output latency
	localparam int unsigned DRAIN_LIMIT   = 20000;
	localparam int unsigned HOLD_CYCLES   = 80;

	// One expected pixel run
	typedef struct packed {
		logic [srld_pkg::WIDTH_W-1:0] length;
		logic [srld_pkg::IDX_W-1:0]   clut;
		logic                         opq;
		logic                         eol;
		logic                         last_of_byte;
	} run_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     data_byte;
	logic                           out_valid;
	logic                           out_stall;
	logic [srld_pkg::WIDTH_W-1:0]   run_length;
	logic [srld_pkg::IDX_W-1:0]     clut_index;
	logic                           opaque;
	logic                           end_of_line;
	logic                           last;
	logic                           cfg_we;
	logic [srld_pkg::CFG_A_W-1:0]   cfg_index;
	logic [srld_pkg::MAP_W-1:0]     cfg_data;

	// Decoder copy: registers and line state
	logic [srld_pkg::WIDTH_W-1:0]   width_cfg;
	logic [srld_pkg::MAP_W-1:0]     palette_cfg;
	logic [srld_pkg::MAP_W-1:0]     alpha_cfg;
	logic [15:0]                    code_acc;
	logic [1:0]                     nib_cnt;
	logic [srld_pkg::WIDTH_W-1:0]   col_pos;

	run_t                 pending_runs[$];
	logic [3:0]           nib_q[$];

	int errors      = 0;
	int bytes_sent  = 0;
	int runs_seen   = 0;
	int lines_seen  = 0;
	int tx_idle_pct = 24;
	int rx_idle_pct = 24;
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	subpicture_rle_line_decoder_core #(
		.MAX_LINE_WIDTH(MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.run_length(run_length),
		.clut_index(clut_index),
		.opaque(opaque),
		.end_of_line(end_of_line),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Decode one byte, nibble by nibble, and queue the runs it closes
	task automatic predict_runs(input logic [7:0] b);
		logic [15:0] code;
		logic [1:0]  colour;
		int unsigned cnt, w, remain, len, num;
		bit          done, line_over;
		run_t        r;
		run_t        fresh[$];
		line_over = 1'b0;
		for (int i = 0; i < 2; i++) begin
			if (!line_over) begin
				code = {code_acc[11:0], (i == 0) ? b[7:4] : b[3:0]};
				cnt  = nib_cnt + 1;
				case (cnt)
					1: done = (code >= srld_pkg::THR_1NIB);
					2: done = (code >= srld_pkg::THR_2NIB);
					3: done = (code >= srld_pkg::THR_3NIB);
					default: done = 1'b1;
				endcase
				if (!done) begin
					code_acc = code;
					nib_cnt  = cnt[1:0];
				end else begin
					code_acc = '0;
					nib_cnt  = '0;
					// four-nibble code below the run range is a carriage return
					if (cnt == 4 && code < srld_pkg::THR_CR)
						code = '0;
					w = 32'(width_cfg);
					if (w == 0)
						w = 1;
					if (w > MAX_W)
						w = MAX_W;
					remain = (w > col_pos) ? w - col_pos : 0;
					if (code == 0) begin
						r.length = srld_pkg::WIDTH_W'(remain);
						r.clut   = '0;
						r.opq    = 1'b0;
						r.eol    = 1'b1;
					end else begin
						num      = 32'(code >> 2);
						colour   = code[1:0];
						len      = (num < remain) ? num : remain;
						r.length = srld_pkg::WIDTH_W'(len);
						r.clut   = palette_cfg[4*colour +: 4];
						r.opq    = alpha_cfg[4*colour + 3];
						r.eol    = (col_pos + len >= w);
					end
					r.last_of_byte = 1'b0;
					fresh.push_back(r);
					// line end drops whatever is left of the byte
					if (r.eol) begin
						col_pos   = '0;
						line_over = 1'b1;
					end else begin
						col_pos = col_pos + r.length;
					end
				end
			end
		end
		foreach (fresh[k]) begin
			r = fresh[k];
			r.last_of_byte = (k == fresh.size() - 1);
			pending_runs.push_back(r);
		end
	endtask

	// Offer one byte, hold it until taken, then maybe idle
	task automatic send_byte(input logic [7:0] b);
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_runs(b);
		bytes_sent++;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every expected run, then let the pipe empty
	task automatic wait_idle();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (pending_runs.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers, one per cycle; only called while idle
	task automatic set_config(input logic [srld_pkg::MAP_W-1:0] w,
			input logic [srld_pkg::MAP_W-1:0] p, input logic [srld_pkg::MAP_W-1:0] a);
		cfg_we    <= 1'b1;
		cfg_index <= srld_pkg::REG_LINE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		width_cfg = w[srld_pkg::WIDTH_W-1:0];
		cfg_index <= srld_pkg::REG_PALETTE_MAP;
		cfg_data  <= p;
		@(posedge clk);
		palette_cfg = p;
		cfg_index <= srld_pkg::REG_ALPHA_MAP;
		cfg_data  <= a;
		@(posedge clk);
		alpha_cfg = a;
		cfg_we <= 1'b0;
	endtask

	// Queue the nibbles of one random code, weighted toward real runs
	task automatic push_code();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			nib_q.push_back(4'($urandom_range(4, 15)));
		end else if (pick < 55) begin
			nib_q.push_back(4'($urandom_range(1, 3)));
			nib_q.push_back(4'($urandom_range(15)));
		end else if (pick < 70) begin
			nib_q.push_back(4'h0);
			nib_q.push_back(4'($urandom_range(4, 15)));
			nib_q.push_back(4'($urandom_range(15)));
		end else if (pick < 82) begin
			nib_q.push_back(4'h0);
			nib_q.push_back(4'($urandom_range(1, 3)));
			nib_q.push_back(4'($urandom_range(15)));
			nib_q.push_back(4'($urandom_range(15)));
		end else if (pick < 90) begin
			// carriage return
			nib_q.push_back(4'h0);
			nib_q.push_back(4'h0);
			nib_q.push_back(4'($urandom_range(15)));
			nib_q.push_back(4'($urandom_range(15)));
		end else begin
			nib_q.push_back(4'($urandom_range(15)));
			nib_q.push_back(4'($urandom_range(15)));
		end
	endtask

	task automatic send_codes(input int n_bytes);
		int         sent;
		logic [3:0] hi, lo;
		sent = 0;
		while (sent < n_bytes) begin
			push_code();
			while (nib_q.size() >= 2 && sent < n_bytes) begin
				hi = nib_q.pop_front();
				lo = nib_q.pop_front();
				send_byte({hi, lo});
				sent++;
			end
		end
	endtask

	// Compare one accepted run with the oldest expectation
	task automatic check_run();
		run_t want;
		runs_seen++;
		if (end_of_line)
			lines_seen++;
		if (pending_runs.size() == 0) begin
			$error("unexpected run: run_length %0d clut_index %0d", run_length, clut_index);
			errors++;
		end else begin
			want = pending_runs.pop_front();
			if (run_length !== want.length) begin
				$error("run_length: expected %0d, actual %0d", want.length, run_length);
				errors++;
			end
			if (clut_index !== want.clut) begin
				$error("clut_index: expected %0d, actual %0d", want.clut, clut_index);
				errors++;
			end
			if (opaque !== want.opq) begin
				$error("opaque: expected %0b, actual %0b", want.opq, opaque);
				errors++;
			end
			if (end_of_line !== want.eol) begin
				$error("end_of_line: expected %0b, actual %0b", want.eol, end_of_line);
				errors++;
			end
			if (last !== want.last_of_byte) begin
				$error("last: expected %0b, actual %0b", want.last_of_byte, last);
				errors++;
			end
		end
	endtask

	// Receiver: check runs, random stall, long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_run();
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// One-, two-, three- and four-nibble codes; carriage return drops the low nibble
	task automatic test_code_lengths();
		send_byte(8'h13); send_byte(8'h05); send_byte(8'hA4);
		send_byte(8'h01); send_byte(8'h23);
		send_byte(8'h40); send_byte(8'h00); send_byte(8'h07);
		wait_idle();
	endtask

	// Narrow line: runs clipped at the edge, line end on the high nibble
	task automatic test_line_clipping();
		set_config(16'd10, 16'h9A5C, 16'h8F70);
		send_byte(8'h1F); send_byte(8'hF7);
		send_byte(8'hFF); send_byte(8'h2F);
		send_byte(8'h03); send_byte(8'hFC);
		wait_idle();
	endtask

	// Width of zero acts as one, width above the maximum is clamped
	task automatic test_width_extremes();
		set_config(16'd0, 16'h3210, 16'h8080);
		send_byte(8'h45); send_byte(8'h00); send_byte(8'h00);
		wait_idle();
		set_config(16'd8191, 16'hFEDC, 16'hFFFF);
		send_byte(8'h03); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
		wait_idle();
	endtask

	// Width lowered below the column: zero-length closing run, for a run and a CR
	task automatic test_width_lowered();
		set_config(16'd720, 16'h4B2D, 16'h0F08);
		send_byte(8'h03); send_byte(8'hFF);
		wait_idle();
		set_config(16'd100, 16'h4B2D, 16'h0F08);
		send_byte(8'h45);
		wait_idle();
		set_config(16'd720, 16'h4B2D, 16'h0F08);
		send_byte(8'h03); send_byte(8'hFF);
		wait_idle();
		set_config(16'd100, 16'h4B2D, 16'h0F08);
		send_byte(8'h00); send_byte(8'h00);
		wait_idle();
	endtask

	// Receiver holds off while bytes keep coming, so the input queue backs up
	task automatic test_backpressure();
		set_config(16'($urandom_range(1, 16)), 16'hFFFF, 16'h0000);
		tx_idle_pct = 0;
		hold_requests++;
		send_codes(40);
		tx_idle_pct = 24;
		send_codes(50);
		wait_idle();
	endtask

	// Random code streams over a spread of widths and maps
	task automatic test_random_streams();
		// no idling on either side
		set_config(16'd4096, 16'h0000, 16'hFFFF);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_codes(80);
		wait_idle();
		tx_idle_pct = 24;
		rx_idle_pct = 24;
		// upper data bits set on the width write: width reads as zero
		set_config(16'hE000, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
		send_codes(40);
		wait_idle();
		set_config(16'd8191, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
		send_codes(70);
		wait_idle();
		set_config(16'(srld_pkg::LINE_WIDTH_RST), 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)));
		send_codes(50);
		// sender pauses until everything has drained, then resumes
		wait_idle();
		send_codes(40);
		wait_idle();
		set_config(16'($urandom_range(1, 4096)), 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)));
		send_codes(90);
		wait_idle();
		set_config(16'($urandom_range(17, 200)), 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)));
		send_codes(60);
		wait_idle();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = srld_pkg::REG_LINE_WIDTH;
		cfg_data  = '0;
		width_cfg   = srld_pkg::LINE_WIDTH_RST;
		palette_cfg = srld_pkg::PALETTE_MAP_RST;
		alpha_cfg   = srld_pkg::ALPHA_MAP_RST;
		code_acc    = '0;
		nib_cnt     = '0;
		col_pos     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_code_lengths();
		test_line_clipping();
		test_width_extremes();
		test_width_lowered();
		test_backpressure();
		test_random_streams();

		wait_idle();
		if (pending_runs.size() != 0) begin
			$error("%0d expected runs never arrived", pending_runs.size());
			errors++;
		end
		$display("Covered %0d bytes, %0d runs and %0d line ends at widths from 1 to the clamp,",
			bytes_sent, runs_seen, lines_seen);
		$display("with random stalls, a long output hold-off and drained pauses.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### subpicture_rle_line_decoder_core.f
hdl/srld_pkg.sv
hdl/srld_front.sv
hdl/srld_back.sv
hdl/subpicture_rle_line_decoder_core.sv
verif/tb_top.sv
